>>> src/pitc_pkg.sv
// shared widths, register indexes and stage-advance struct for the
// closed point-in-triangle pipeline; no dependencies
package pitc_pkg;

   localparam int COORD_BITS  = 24;
   localparam int FIELD_COUNT = 8;
   localparam int REQ_W       = ((FIELD_COUNT * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_W       = 8;

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int SUM_W  = PROD_W + 1;

   localparam int REL_W  = 32;
   localparam int ABS_W  = 48;
   localparam int CSR_W  = 48;
   localparam int ADDR_W = 2;

   // split of the edge length for the tolerance multiply
   localparam int LO_W    = (SUM_W + 1) / 2;
   localparam int HI_W    = SUM_W - LO_W;
   localparam int MULT_W  = SUM_W + REL_W;
   localparam int ABS_CMP_W = (SUM_W > ABS_W) ? SUM_W : ABS_W;

   localparam logic [ADDR_W-1:0] CSR_CLOSED_EDGES = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] CSR_REL_TOL      = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] CSR_ABS_TOL      = ADDR_W'(2);

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } pitc_adv_type;

endpackage

>>> src/pitc_edge.sv
// one edge of the closed test: collinearity within tolerance and projection bounds
// uses pitc_pkg; stages follow the top level's advance strobes
module pitc_edge (
   input  logic                                  clock,
   input  pitc_pkg::pitc_adv_type                adv,
   input  logic signed [pitc_pkg::COORD_BITS-1:0] p_x,
   input  logic signed [pitc_pkg::COORD_BITS-1:0] p_y,
   input  logic signed [pitc_pkg::COORD_BITS-1:0] s_x,
   input  logic signed [pitc_pkg::COORD_BITS-1:0] s_y,
   input  logic signed [pitc_pkg::COORD_BITS-1:0] e_x,
   input  logic signed [pitc_pkg::COORD_BITS-1:0] e_y,
   input  logic        [pitc_pkg::REL_W-1:0]      rel_tol,
   input  logic        [pitc_pkg::ABS_W-1:0]      abs_tol,
   output logic                                  on_edge
);

   // stage 1: differences
   logic signed [pitc_pkg::DIFF_W-1:0] a0_in, a1_in, b0_in, b1_in;
   logic signed [pitc_pkg::DIFF_W-1:0] a0_ff, a1_ff, b0_ff, b1_ff;

   // stage 2: products
   logic signed [pitc_pkg::PROD_W-1:0] cr0_in, cr1_in, lb0_in, lb1_in;
   logic signed [pitc_pkg::PROD_W-1:0] dt0_in, dt1_in, la0_in, la1_in;
   logic signed [pitc_pkg::PROD_W-1:0] cr0_ff, cr1_ff, lb0_ff, lb1_ff;
   logic signed [pitc_pkg::PROD_W-1:0] dt0_ff, dt1_ff, la0_ff, la1_ff;

   // stage 3: sums
   logic signed [pitc_pkg::SUM_W-1:0] cross_w;
   logic        [pitc_pkg::SUM_W-1:0] n_in, n_ff;
   logic signed [pitc_pkg::SUM_W-1:0] len_b_in, len_a_in, dot_in;
   logic signed [pitc_pkg::SUM_W-1:0] len_b_ff, len_a_ff, dot_ff;

   // stage 4: tolerance partial products and flags
   logic [pitc_pkg::LO_W+pitc_pkg::REL_W-1:0] pp_lo_in, pp_lo_ff;
   logic [pitc_pkg::HI_W+pitc_pkg::REL_W-1:0] pp_hi_in, pp_hi_ff;
   logic [pitc_pkg::SUM_W-1:0]                n4_ff;
   logic zero_len_in, abs_ok_in, dot_ok_in, len_ok_in;
   logic zero_len_ff, abs_ok_ff, dot_ok_ff, len_ok_ff;

   logic [pitc_pkg::MULT_W-1:0] tol_prod;
   logic [pitc_pkg::MULT_W-1:0] n_scaled;
   logic                        rel_ok;

   assign a0_in = pitc_pkg::DIFF_W'(p_x) - pitc_pkg::DIFF_W'(s_x);
   assign a1_in = pitc_pkg::DIFF_W'(p_y) - pitc_pkg::DIFF_W'(s_y);
   assign b0_in = pitc_pkg::DIFF_W'(e_x) - pitc_pkg::DIFF_W'(s_x);
   assign b1_in = pitc_pkg::DIFF_W'(e_y) - pitc_pkg::DIFF_W'(s_y);

   assign cr0_in = a0_ff * b1_ff;
   assign cr1_in = a1_ff * b0_ff;
   assign lb0_in = b0_ff * b0_ff;
   assign lb1_in = b1_ff * b1_ff;
   assign dt0_in = a0_ff * b0_ff;
   assign dt1_in = a1_ff * b1_ff;
   assign la0_in = a0_ff * a0_ff;
   assign la1_in = a1_ff * a1_ff;

   assign cross_w  = pitc_pkg::SUM_W'(cr0_ff) - pitc_pkg::SUM_W'(cr1_ff);
   assign n_in     = cross_w[pitc_pkg::SUM_W-1] ? $unsigned(-cross_w) : $unsigned(cross_w);
   assign len_b_in = pitc_pkg::SUM_W'(lb0_ff) + pitc_pkg::SUM_W'(lb1_ff);
   assign len_a_in = pitc_pkg::SUM_W'(la0_ff) + pitc_pkg::SUM_W'(la1_ff);
   assign dot_in   = pitc_pkg::SUM_W'(dt0_ff) + pitc_pkg::SUM_W'(dt1_ff);

   assign pp_lo_in    = pitc_pkg::LO_W'(len_b_ff[pitc_pkg::LO_W-1:0]) * rel_tol;
   assign pp_hi_in    = pitc_pkg::HI_W'(len_b_ff[pitc_pkg::SUM_W-1:pitc_pkg::LO_W]) * rel_tol;
   assign zero_len_in = (len_b_ff == '0);
   assign abs_ok_in   = pitc_pkg::ABS_CMP_W'(n_ff) <= pitc_pkg::ABS_CMP_W'(abs_tol);
   assign dot_ok_in   = !dot_ff[pitc_pkg::SUM_W-1];
   assign len_ok_in   = len_a_ff <= len_b_ff;

   // stage 5 is the top level's output register
   assign tol_prod = (pitc_pkg::MULT_W'(pp_hi_ff) << pitc_pkg::LO_W)
                   + pitc_pkg::MULT_W'(pp_lo_ff);
   assign n_scaled = pitc_pkg::MULT_W'(n4_ff) << pitc_pkg::REL_W;
   assign rel_ok   = n_scaled <= tol_prod;
   assign on_edge  = (zero_len_ff ? abs_ok_ff : rel_ok) && dot_ok_ff && len_ok_ff;

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         a0_ff <= a0_in;
         a1_ff <= a1_in;
         b0_ff <= b0_in;
         b1_ff <= b1_in;
      end
      if (adv.s2) begin
         cr0_ff <= cr0_in;
         cr1_ff <= cr1_in;
         lb0_ff <= lb0_in;
         lb1_ff <= lb1_in;
         dt0_ff <= dt0_in;
         dt1_ff <= dt1_in;
         la0_ff <= la0_in;
         la1_ff <= la1_in;
      end
      if (adv.s3) begin
         n_ff     <= n_in;
         len_b_ff <= len_b_in;
         len_a_ff <= len_a_in;
         dot_ff   <= dot_in;
      end
      if (adv.s4) begin
         pp_lo_ff    <= pp_lo_in;
         pp_hi_ff    <= pp_hi_in;
         n4_ff       <= n_ff;
         zero_len_ff <= zero_len_in;
         abs_ok_ff   <= abs_ok_in;
         dot_ok_ff   <= dot_ok_in;
         len_ok_ff   <= len_ok_in;
      end
   end

endmodule

>>> src/point_in_triangle_closed.sv
// top level of the closed point-in-triangle tester: stream channels, control
// registers, interior test and the five-stage pipeline; uses pitc_pkg and pitc_edge
//
// usage
//  - req_ channel: one beat per query, a point and three vertices, all signed
//    COORD_BITS coordinates packed from point_x in the lowest bits upward
//  - rsp_ channel: one beat per query, bit 0 of rsp_tdata is inside_res
//  - csr_ port: csr_we with csr_addr 0 closed_edges, 1 rel_tol, 2 abs_tol;
//    other indexes are ignored; write only while no query is in flight
//  - throughput: one query per cycle while rsp_tready is high; five register
//    stages (differences, products, sums, tolerance multiply and compares,
//    output) each move one beat per cycle
//  - stall: each stage advances when it is empty or the next stage advances,
//    so bubbles are squeezed out and req_tready stays high while any stage
//    is free; nothing is dropped or repeated while rsp_tready is low
//  - reset: all stages empty, closed_edges = 1, both tolerances zero
module point_in_triangle_closed (
   input  logic                          clock,
   input  logic                          reset,
   // point_x, point_y, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
   // vertex_c_x, vertex_c_y (lowest bits first)
   input  logic [pitc_pkg::REQ_W-1:0]    req_tdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // inside_res in bit 0, zeros above
   output logic [pitc_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_we,
   input  logic [pitc_pkg::ADDR_W-1:0]   csr_addr,
   input  logic [pitc_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int CB = pitc_pkg::COORD_BITS;

   // control registers
   logic                       closed_ff;
   logic [pitc_pkg::REL_W-1:0] rel_tol_ff;
   logic [pitc_pkg::ABS_W-1:0] abs_tol_ff;

   // input fields
   logic signed [CB-1:0] px, py, ax, ay, bx, by, cx, cy;

   // per-stage valid bits, stage 1 .. 5
   logic [5:1] vld_ff;
   logic [5:1] adv;
   pitc_pkg::pitc_adv_type edge_adv;

   // bounding rejection travels alongside
   logic reject_in;
   logic reject_s1_ff, reject_s2_ff, reject_s3_ff, reject_s4_ff;

   // interior datapath
   logic signed [pitc_pkg::DIFF_W-1:0] v0x_in, v0y_in, v1x_in, v1y_in, vx_in, vy_in;
   logic signed [pitc_pkg::DIFF_W-1:0] v0x_ff, v0y_ff, v1x_ff, v1y_ff, vx_ff, vy_ff;
   logic signed [pitc_pkg::PROD_W-1:0] m0_in, m1_in, m2_in, m3_in, m4_in, m5_in;
   logic signed [pitc_pkg::PROD_W-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [pitc_pkg::SUM_W-1:0]  d_in, ca_in, cb_in;
   logic signed [pitc_pkg::SUM_W-1:0]  d_ff, ca_ff, cb_ff;
   logic signed [pitc_pkg::SUM_W:0]    weight_sum;
   logic                               inside_in, inside_s4_ff;

   logic edge_ab, edge_bc, edge_ca;
   logic inside_res_in, inside_res_ff;

   assign px = req_tdata[0*CB +: CB];
   assign py = req_tdata[1*CB +: CB];
   assign ax = req_tdata[2*CB +: CB];
   assign ay = req_tdata[3*CB +: CB];
   assign bx = req_tdata[4*CB +: CB];
   assign by = req_tdata[5*CB +: CB];
   assign cx = req_tdata[6*CB +: CB];
   assign cy = req_tdata[7*CB +: CB];

   // stage advance: a stage moves when empty or when the next one moves
   assign adv[5] = !vld_ff[5] || rsp_tready;
   assign adv[4] = !vld_ff[4] || adv[5];
   assign adv[3] = !vld_ff[3] || adv[4];
   assign adv[2] = !vld_ff[2] || adv[3];
   assign adv[1] = !vld_ff[1] || adv[2];
   assign req_tready = adv[1];

   assign edge_adv.s1 = adv[1];
   assign edge_adv.s2 = adv[2];
   assign edge_adv.s3 = adv[3];
   assign edge_adv.s4 = adv[4];

   // point strictly beyond every vertex on one side of an axis
   assign reject_in = (px < ax && px < bx && px < cx)
                   || (px > ax && px > bx && px > cx)
                   || (py < ay && py < by && py < cy)
                   || (py > ay && py > by && py > cy);

   // stage 1: edge vectors from vertex a
   assign v0x_in = pitc_pkg::DIFF_W'(cx) - pitc_pkg::DIFF_W'(ax);
   assign v0y_in = pitc_pkg::DIFF_W'(cy) - pitc_pkg::DIFF_W'(ay);
   assign v1x_in = pitc_pkg::DIFF_W'(bx) - pitc_pkg::DIFF_W'(ax);
   assign v1y_in = pitc_pkg::DIFF_W'(by) - pitc_pkg::DIFF_W'(ay);
   assign vx_in  = pitc_pkg::DIFF_W'(px) - pitc_pkg::DIFF_W'(ax);
   assign vy_in  = pitc_pkg::DIFF_W'(py) - pitc_pkg::DIFF_W'(ay);

   // stage 2: cross-product terms
   assign m0_in = v0x_ff * v1y_ff;
   assign m1_in = v0y_ff * v1x_ff;
   assign m2_in = vx_ff * v1y_ff;
   assign m3_in = vy_ff * v1x_ff;
   assign m4_in = v0x_ff * vy_ff;
   assign m5_in = v0y_ff * vx_ff;

   // stage 3: determinant and the two unnormalized weights
   assign d_in  = pitc_pkg::SUM_W'(m0_ff) - pitc_pkg::SUM_W'(m1_ff);
   assign ca_in = pitc_pkg::SUM_W'(m2_ff) - pitc_pkg::SUM_W'(m3_ff);
   assign cb_in = pitc_pkg::SUM_W'(m4_ff) - pitc_pkg::SUM_W'(m5_ff);

   // stage 4: strict interior, signs folded by the sign of the determinant
   assign weight_sum = (pitc_pkg::SUM_W+1)'(ca_ff) + (pitc_pkg::SUM_W+1)'(cb_ff);

   always_comb begin
      inside_in = 1'b0;
      if (d_ff > 0) begin
         inside_in = (ca_ff > 0) && (cb_ff > 0)
                  && (weight_sum < (pitc_pkg::SUM_W+1)'(d_ff));
      end else if (d_ff < 0) begin
         inside_in = (ca_ff < 0) && (cb_ff < 0)
                  && (weight_sum > (pitc_pkg::SUM_W+1)'(d_ff));
      end
   end

   pitc_edge u_edge_ab (
      .clock   (clock),
      .adv     (edge_adv),
      .p_x     (px),
      .p_y     (py),
      .s_x     (ax),
      .s_y     (ay),
      .e_x     (bx),
      .e_y     (by),
      .rel_tol (rel_tol_ff),
      .abs_tol (abs_tol_ff),
      .on_edge (edge_ab)
   );

   pitc_edge u_edge_bc (
      .clock   (clock),
      .adv     (edge_adv),
      .p_x     (px),
      .p_y     (py),
      .s_x     (bx),
      .s_y     (by),
      .e_x     (cx),
      .e_y     (cy),
      .rel_tol (rel_tol_ff),
      .abs_tol (abs_tol_ff),
      .on_edge (edge_bc)
   );

   pitc_edge u_edge_ca (
      .clock   (clock),
      .adv     (edge_adv),
      .p_x     (px),
      .p_y     (py),
      .s_x     (cx),
      .s_y     (cy),
      .e_x     (ax),
      .e_y     (ay),
      .rel_tol (rel_tol_ff),
      .abs_tol (abs_tol_ff),
      .on_edge (edge_ca)
   );

   // stage 5: final verdict into the output register
   assign inside_res_in = !reject_s4_ff
                       && (inside_s4_ff || (closed_ff && (edge_ab || edge_bc || edge_ca)));

   assign rsp_tvalid = vld_ff[5];
   assign rsp_tdata  = {{(pitc_pkg::RSP_W-1){1'b0}}, inside_res_ff};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff  <= 1'b1;
         rel_tol_ff <= '0;
         abs_tol_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            pitc_pkg::CSR_CLOSED_EDGES: closed_ff  <= csr_wdata[0];
            pitc_pkg::CSR_REL_TOL:      rel_tol_ff <= csr_wdata[pitc_pkg::REL_W-1:0];
            pitc_pkg::CSR_ABS_TOL:      abs_tol_ff <= csr_wdata[pitc_pkg::ABS_W-1:0];
            default: ;
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[1]) vld_ff[1] <= req_tvalid;
         if (adv[2]) vld_ff[2] <= vld_ff[1];
         if (adv[3]) vld_ff[3] <= vld_ff[2];
         if (adv[4]) vld_ff[4] <= vld_ff[3];
         if (adv[5]) vld_ff[5] <= vld_ff[4];
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         reject_s1_ff <= reject_in;
         v0x_ff       <= v0x_in;
         v0y_ff       <= v0y_in;
         v1x_ff       <= v1x_in;
         v1y_ff       <= v1y_in;
         vx_ff        <= vx_in;
         vy_ff        <= vy_in;
      end
      if (adv[2]) begin
         reject_s2_ff <= reject_s1_ff;
         m0_ff        <= m0_in;
         m1_ff        <= m1_in;
         m2_ff        <= m2_in;
         m3_ff        <= m3_in;
         m4_ff        <= m4_in;
         m5_ff        <= m5_in;
      end
      if (adv[3]) begin
         reject_s3_ff <= reject_s2_ff;
         d_ff         <= d_in;
         ca_ff        <= ca_in;
         cb_ff        <= cb_in;
      end
      if (adv[4]) begin
         reject_s4_ff <= reject_s3_ff;
         inside_s4_ff <= inside_in;
      end
      if (adv[5]) begin
         inside_res_ff <= inside_res_in;
      end
   end

`ifndef SYNTH
   // with every stage full, input readiness follows the output side exactly
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff == '1) |-> (req_tready == rsp_tready))
      else $error("pipeline full but req_tready does not follow rsp_tready");

   // a rejected query always comes out as outside
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && adv[5] && reject_s4_ff) |=> (rsp_tdata[0] == 1'b0))
      else $error("rejected query reported inside");

   // in open mode the verdict is the strict interior test alone
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && adv[5] && !closed_ff)
         |=> (rsp_tdata[0] == $past(inside_s4_ff && !reject_s4_ff)))
      else $error("open-mode verdict differs from interior test");

   // reset leaves the pipeline empty
   assert property (@(posedge clock)
      $past(reset) |-> (vld_ff == '0))
      else $error("stage valid set right after reset");
`endif

endmodule

>>> verif/testbench.sv
// self-checking bench for point_in_triangle_closed: directed table, then randomized
// query mixes under several tolerance settings with random stalls on both channels
// depends on pitc_pkg and the point_in_triangle_closed rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASE_ITEMS  = 313;
   localparam int PHASE_COUNT  = 6;
   localparam int REPORT_LIMIT = 10;
   localparam int C_MIN = -(1 << (pitc_pkg::COORD_BITS - 1));
   localparam int C_MAX = (1 << (pitc_pkg::COORD_BITS - 1)) - 1;

   // index past the register list, writes there must be dropped
   localparam logic [pitc_pkg::ADDR_W-1:0] CSR_SPARE = pitc_pkg::ADDR_W'(3);

   typedef logic signed [pitc_pkg::COORD_BITS-1:0] coord_type;
   // wide enough that no product or sum of the edge test can wrap
   typedef logic signed [127:0] acc_type;

   // one query beat; the last member lands in the lowest bits of req_tdata
   typedef struct packed {
      coord_type cy;
      coord_type cx;
      coord_type by;
      coord_type bx;
      coord_type ay;
      coord_type ax;
      coord_type py;
      coord_type px;
   } query_type;

   typedef enum {ROW_QUERY, ROW_WRITE} row_kind_type;
   typedef enum {CHECK_MODEL, CHECK_OUT, CHECK_IN} row_check_type;

   typedef struct {
      row_kind_type                kind;
      query_type                   q;
      row_check_type               check;
      logic [pitc_pkg::ADDR_W-1:0] addr;
      logic [pitc_pkg::CSR_W-1:0]  value;
   } row_type;

   typedef struct {
      query_type q;
      logic      in_tri;
   } verdict_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   // point_x, point_y, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
   // vertex_c_x, vertex_c_y (lowest bits first)
   logic [pitc_pkg::REQ_W-1:0]  req_tdata = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   // inside_res in bit 0, zeros above
   logic [pitc_pkg::RSP_W-1:0]  rsp_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic                        csr_we = 1'b0;
   logic [pitc_pkg::ADDR_W-1:0] csr_addr = '0;
   logic [pitc_pkg::CSR_W-1:0]  csr_wdata = '0;

   // mirror of the control registers as the block should hold them
   logic                        closed_mode = 1'b1;
   logic [pitc_pkg::REL_W-1:0]  rel_frac = '0;
   logic [pitc_pkg::ABS_W-1:0]  abs_limit = '0;

   verdict_type verdicts[$];
   row_type     plan[$];
   int          error_count = 0;
   int          cycle_count = 0;
   // 0 means no idling on either channel, otherwise roughly one burst per gap_odds
   int          gap_odds = 0;

   point_in_triangle_closed i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor of the inside flag
   // ------------------------------------------------------------------

   function automatic acc_type widen(coord_type c);
      return acc_type'(c);
   endfunction

   function automatic acc_type cross_z(acc_type ax, acc_type ay, acc_type bx, acc_type by);
      return ax * by - ay * bx;
   endfunction

   // point on segment s->e: collinear within tolerance and inside the projection
   function automatic logic touches_edge(acc_type px, acc_type py, acc_type sx, acc_type sy,
                                         acc_type ex, acc_type ey);
      acc_type a0, a1, b0, b1, n, len_b, len_a, dot;
      logic near;
      a0 = px - sx;
      a1 = py - sy;
      b0 = ex - sx;
      b1 = ey - sy;
      n = cross_z(a0, a1, b0, b1);
      if (n < 0) n = -n;
      len_b = b0 * b0 + b1 * b1;
      // zero-length edge falls back to the absolute tolerance
      if (len_b == 0) near = n <= acc_type'(abs_limit);
      else near = (n <<< 32) <= len_b * acc_type'(rel_frac);
      if (!near) return 1'b0;
      dot = a0 * b0 + a1 * b1;
      if (dot < 0) return 1'b0;
      len_a = a0 * a0 + a1 * a1;
      return len_a <= len_b;
   endfunction

   function automatic logic predict_inside(query_type q);
      acc_type px, py, ax, ay, bx, by, cx, cy;
      acc_type v0x, v0y, v1x, v1y, vx, vy, d, ca, cb;
      logic hit;
      px = widen(q.px);
      py = widen(q.py);
      ax = widen(q.ax);
      ay = widen(q.ay);
      bx = widen(q.bx);
      by = widen(q.by);
      cx = widen(q.cx);
      cy = widen(q.cy);
      // strictly beyond every vertex on one axis: out at once
      if ((px < ax && px < bx && px < cx) || (px > ax && px > bx && px > cx) ||
          (py < ay && py < by && py < cy) || (py > ay && py > by && py > cy))
         return 1'b0;
      v0x = cx - ax;
      v0y = cy - ay;
      v1x = bx - ax;
      v1y = by - ay;
      vx = px - ax;
      vy = py - ay;
      hit = 1'b0;
      d = cross_z(v0x, v0y, v1x, v1y);
      // barycentric interior without division; degenerate triangle skips it
      if (d != 0) begin
         ca = cross_z(vx, vy, v1x, v1y);
         cb = cross_z(v0x, v0y, vx, vy);
         if (d < 0) begin
            d = -d;
            ca = -ca;
            cb = -cb;
         end
         hit = ca > 0 && cb > 0 && ca + cb < d;
      end
      if (!hit && closed_mode)
         hit = touches_edge(px, py, ax, ay, bx, by) ||
               touches_edge(px, py, bx, by, cx, cy) ||
               touches_edge(px, py, cx, cy, ax, ay);
      return hit;
   endfunction

   // ------------------------------------------------------------------
   // query construction
   // ------------------------------------------------------------------

   function automatic query_type make_query(int px, int py, int ax, int ay,
                                            int bx, int by, int cx, int cy);
      query_type q;
      q.px = coord_type'(px);
      q.py = coord_type'(py);
      q.ax = coord_type'(ax);
      q.ay = coord_type'(ay);
      q.bx = coord_type'(bx);
      q.by = coord_type'(by);
      q.cx = coord_type'(cx);
      q.cy = coord_type'(cy);
      return q;
   endfunction

   function automatic int span_coord(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic int corner_coord();
      unique case ($urandom_range(0, 5))
         0: return C_MIN;
         1: return C_MAX;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return int'(coord_type'($urandom()));
      endcase
   endfunction

   // index 0 is the point, 1..3 the vertices
   function automatic query_type random_query();
      int xs[4], ys[4];
      int pick, role, k, m, dx, dy, u, w, jit;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         // raw noise over the whole field range
         foreach (xs[i]) begin
            xs[i] = int'(coord_type'($urandom()));
            ys[i] = int'(coord_type'($urandom()));
         end
      end else if (pick < 30) begin
         // tiny grid: shared vertices, degenerate triangles, hits on edges
         foreach (xs[i]) begin
            xs[i] = span_coord(6);
            ys[i] = span_coord(6);
         end
      end else if (pick < 60) begin
         // point on the line of one edge, sometimes past its ends or off by one
         role = $urandom_range(1, 3);
         k = $urandom_range(1, 8);
         m = int'($urandom_range(0, k + 2)) - 1;
         dx = span_coord(1 << 14);
         dy = span_coord(1 << 14);
         xs[role] = span_coord(1 << 20);
         ys[role] = span_coord(1 << 20);
         xs[role % 3 + 1] = xs[role] + k * dx;
         ys[role % 3 + 1] = ys[role] + k * dy;
         xs[(role + 1) % 3 + 1] = span_coord(1 << 22);
         ys[(role + 1) % 3 + 1] = span_coord(1 << 22);
         jit = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2)) - 1 : 0;
         xs[0] = xs[role] + m * dx + jit;
         jit = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2)) - 1 : 0;
         ys[0] = ys[role] + m * dy + jit;
      end else if (pick < 85) begin
         // point as a weighted blend of the vertices, mostly inside
         for (int i = 1; i < 4; i++) begin
            xs[i] = span_coord(1 << 22);
            ys[i] = span_coord(1 << 22);
         end
         u = $urandom_range(0, 16);
         w = $urandom_range(0, 17 - u);
         xs[0] = xs[1] + ((xs[2] - xs[1]) * u + (xs[3] - xs[1]) * w) / 16;
         ys[0] = ys[1] + ((ys[2] - ys[1]) * u + (ys[3] - ys[1]) * w) / 16;
      end else begin
         foreach (xs[i]) begin
            xs[i] = corner_coord();
            ys[i] = corner_coord();
         end
      end
      return make_query(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3]);
   endfunction

   // ------------------------------------------------------------------
   // directed table
   // ------------------------------------------------------------------

   function automatic void add_query(query_type q, row_check_type check);
      row_type r;
      r.kind = ROW_QUERY;
      r.q = q;
      r.check = check;
      r.addr = '0;
      r.value = '0;
      plan.push_back(r);
   endfunction

   function automatic void add_write(logic [pitc_pkg::ADDR_W-1:0] addr,
                                     logic [pitc_pkg::CSR_W-1:0] value);
      row_type r;
      r.kind = ROW_WRITE;
      r.q = '0;
      r.check = CHECK_MODEL;
      r.addr = addr;
      r.value = value;
      plan.push_back(r);
   endfunction

   function automatic void build_plan();
      // reset settings: closed edges, zero tolerances
      // right triangle (0,0) (100,0) (0,100)
      add_query(make_query(10, 10, 0, 0, 100, 0, 0, 100), CHECK_IN);
      add_query(make_query(200, 200, 0, 0, 100, 0, 0, 100), CHECK_OUT);
      add_query(make_query(50, 0, 0, 0, 100, 0, 0, 100), CHECK_IN);
      add_query(make_query(0, 0, 0, 0, 100, 0, 0, 100), CHECK_IN);
      add_query(make_query(-1, 50, 0, 0, 100, 0, 0, 100), CHECK_OUT);
      add_query(make_query(60, 60, 0, 0, 100, 0, 0, 100), CHECK_OUT);
      // on the hypotenuse: interior test fails, edge test catches it
      add_query(make_query(50, 50, 0, 0, 100, 0, 0, 100), CHECK_IN);
      // full-range triangle
      add_query(make_query(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX),
                CHECK_IN);
      add_query(make_query(0, 0, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX), CHECK_MODEL);
      add_query(make_query(C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX),
                CHECK_MODEL);
      add_query(make_query(-1, -1, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN),
                CHECK_MODEL);
      add_query(make_query(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX),
                CHECK_OUT);
      // degenerate triangle on a line
      add_query(make_query(5, 5, 0, 0, 10, 10, 20, 20), CHECK_IN);
      add_query(make_query(5, 6, 0, 0, 10, 10, 20, 20), CHECK_MODEL);
      // all three vertices coincide, every edge has zero length
      add_query(make_query(7, -3, 7, -3, 7, -3, 7, -3), CHECK_IN);
      add_query(make_query(8, -3, 7, -3, 7, -3, 7, -3), CHECK_OUT);
      // write past the register list must not clear closed mode
      add_write(CSR_SPARE, '0);
      add_query(make_query(50, 0, 0, 0, 100, 0, 0, 100), CHECK_IN);
      // open mode: edges and vertices are outside
      add_write(pitc_pkg::CSR_CLOSED_EDGES, pitc_pkg::CSR_W'(0));
      add_query(make_query(50, 0, 0, 0, 100, 0, 0, 100), CHECK_OUT);
      add_query(make_query(10, 10, 0, 0, 100, 0, 0, 100), CHECK_IN);
      add_query(make_query(0, 0, 0, 0, 100, 0, 0, 100), CHECK_OUT);
      add_query(make_query(7, -3, 7, -3, 7, -3, 7, -3), CHECK_OUT);
      // widest tolerances
      add_write(pitc_pkg::CSR_CLOSED_EDGES, pitc_pkg::CSR_W'(1));
      add_write(pitc_pkg::CSR_REL_TOL, pitc_pkg::CSR_W'({pitc_pkg::REL_W{1'b1}}));
      add_write(pitc_pkg::CSR_ABS_TOL, pitc_pkg::CSR_W'({pitc_pkg::ABS_W{1'b1}}));
      add_query(make_query(60, 60, 0, 0, 100, 0, 0, 100), CHECK_MODEL);
      add_query(make_query(5, 6, 0, 0, 10, 10, 20, 20), CHECK_MODEL);
      add_query(make_query(4, 4, 3, 4, 3, 4, 9, 9), CHECK_MODEL);
   endfunction

   // ------------------------------------------------------------------
   // channel and register drivers
   // ------------------------------------------------------------------

   task automatic hold_off(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   // present one beat and wait for the handshake; tvalid stays up afterwards
   task automatic send_query(query_type q, logic want);
      verdict_type v;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= q;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      v.q = q;
      v.in_tri = want;
      verdicts.push_back(v);
   endtask

   // sender goes quiet until every outstanding verdict has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [pitc_pkg::ADDR_W-1:0] addr,
                            logic [pitc_pkg::CSR_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      unique case (addr)
         pitc_pkg::CSR_CLOSED_EDGES: closed_mode = value[0];
         pitc_pkg::CSR_REL_TOL:      rel_frac = value[pitc_pkg::REL_W-1:0];
         pitc_pkg::CSR_ABS_TOL:      abs_limit = value[pitc_pkg::ABS_W-1:0];
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // result side: random back-pressure and the checker
   // ------------------------------------------------------------------

   initial begin
      forever begin
         if (gap_odds != 0 && $urandom_range(1, gap_odds * 2) == 1) begin
            repeat ($urandom_range(1, 18)) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end else begin
            @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdicts.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected result beat, tdata %h", rsp_tdata);
         end else begin
            v = verdicts.pop_front();
            if (rsp_tdata !== pitc_pkg::RSP_W'(v.in_tri)) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("inside_res mismatch: expected %0d got %h", v.in_tri, rsp_tdata);
                  $display("  p (%0d,%0d) a (%0d,%0d) b (%0d,%0d) c (%0d,%0d)",
                           v.q.px, v.q.py, v.q.ax, v.q.ay,
                           v.q.bx, v.q.by, v.q.cx, v.q.cy);
               end
            end
         end
      end
   end

   // watchdog, far above the slowest legal run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      query_type q;
      logic      want;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed rows, starting from the reset settings, with light idling
      build_plan();
      gap_odds = 4;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            wait_drained();
            write_reg(plan[i].addr, plan[i].value);
         end else begin
            unique case (plan[i].check)
               CHECK_IN:  want = 1'b1;
               CHECK_OUT: want = 1'b0;
               default:   want = predict_inside(plan[i].q);
            endcase
            if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
               hold_off($urandom_range(1, 18));
            send_query(plan[i].q, want);
         end
      end

      // random phases, each with its own register settings and idling rate;
      // the last one runs without any idling
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         unique case (p)
            0: begin
               write_reg(pitc_pkg::CSR_CLOSED_EDGES, pitc_pkg::CSR_W'(1));
               write_reg(pitc_pkg::CSR_REL_TOL, '0);
               write_reg(pitc_pkg::CSR_ABS_TOL, '0);
               gap_odds = 6;
            end
            1: begin
               write_reg(pitc_pkg::CSR_CLOSED_EDGES, pitc_pkg::CSR_W'(0));
               write_reg(pitc_pkg::CSR_REL_TOL, pitc_pkg::CSR_W'($urandom()));
               write_reg(pitc_pkg::CSR_ABS_TOL,
                         pitc_pkg::CSR_W'({$urandom(), $urandom()}));
               gap_odds = 3;
            end
            2: begin
               write_reg(pitc_pkg::CSR_CLOSED_EDGES, pitc_pkg::CSR_W'(1));
               write_reg(pitc_pkg::CSR_REL_TOL,
                         pitc_pkg::CSR_W'({pitc_pkg::REL_W{1'b1}}));
               write_reg(pitc_pkg::CSR_ABS_TOL,
                         pitc_pkg::CSR_W'({pitc_pkg::ABS_W{1'b1}}));
               gap_odds = 8;
            end
            3: begin
               write_reg(pitc_pkg::CSR_REL_TOL, pitc_pkg::CSR_W'($urandom_range(0, 65535)));
               write_reg(pitc_pkg::CSR_ABS_TOL, '0);
               gap_odds = 0;
            end
            4: begin
               write_reg(pitc_pkg::CSR_REL_TOL, pitc_pkg::CSR_W'($urandom()));
               write_reg(pitc_pkg::CSR_ABS_TOL,
                         pitc_pkg::CSR_W'({$urandom(), $urandom()}));
               gap_odds = 4;
            end
            default: begin
               write_reg(pitc_pkg::CSR_CLOSED_EDGES, pitc_pkg::CSR_W'(1));
               write_reg(pitc_pkg::CSR_REL_TOL, pitc_pkg::CSR_W'($urandom()));
               write_reg(pitc_pkg::CSR_ABS_TOL, pitc_pkg::CSR_W'($urandom_range(0, 1000)));
               gap_odds = 0;
            end
         endcase
         repeat (PHASE_ITEMS) begin
            q = random_query();
            if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
               hold_off($urandom_range(1, 18));
            send_query(q, predict_inside(q));
         end
      end

      // drain, then give stray beats a chance to show up
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
